/* hdl/rrqs_pkg.sv */
// ============================================================================
// Round-robin quantum scheduler package
// Shared constants, codes and types for the scheduler and its job store.
// ============================================================================
package rrqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(10);

    // Operation codes
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REQUEUED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [ID_W-1:0]     job_id_t;
    typedef logic [TIME_W-1:0]   job_time_t;
    typedef logic [STATUS_W-1:0] status_t;

    typedef struct packed {
        job_id_t   id;
        job_time_t remaining;
    } entry_t;

    typedef struct packed {
        logic   en;
        ptr_t   addr;
        entry_t data;
    } store_wr_t;

    typedef struct packed {
        logic en;
        ptr_t addr;
    } store_rd_t;

    localparam ptr_t LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam cnt_t FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    function automatic ptr_t next_slot(input ptr_t p);
        return (p == LAST_SLOT) ? '0 : p + ptr_t'(1);
    endfunction

endpackage

/* hdl/rrqs_if.sv */
// ============================================================================
// Round-robin quantum scheduler channels
// Valid/ready channels for job items, results and quantum writes.
// ============================================================================
interface rrqs_item_if;
    logic                  valid;
    logic                  ready;
    logic                  op;
    rrqs_pkg::job_id_t     job_id;
    rrqs_pkg::job_time_t   duration;

    modport source (output valid, output op, output job_id, output duration, input ready);
    modport sink   (input valid, input op, input job_id, input duration, output ready);
endinterface

interface rrqs_result_if;
    logic                  valid;
    logic                  ready;
    rrqs_pkg::status_t     status;
    rrqs_pkg::job_id_t     ran_id;
    rrqs_pkg::job_time_t   slice_len;
    rrqs_pkg::job_time_t   remaining;

    modport source (output valid, output status, output ran_id, output slice_len,
                    output remaining, input ready);
    modport sink   (input valid, input status, input ran_id, input slice_len,
                    input remaining, output ready);
endinterface

interface rrqs_cfg_if;
    logic                  valid;
    logic                  ready;
    rrqs_pkg::job_time_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rrqs_store.sv */
// ============================================================================
// Job store
// Synchronous memory of queued jobs, one write and one registered read port.
// ============================================================================
module rrqs_store (
    input  logic               clk,
    input  rrqs_pkg::store_wr_t wr,
    input  rrqs_pkg::store_rd_t rd,
    output rrqs_pkg::entry_t    rd_data
);
    import rrqs_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/round_robin_quantum_scheduler.sv */
// ============================================================================
// Round-robin quantum scheduler
// Time-slice scheduler over a circular queue of jobs held in a memory.
// ============================================================================
// Channels: item carries op, job_id and duration; result returns status,
// ran_id, slice_len and remaining, one result per item in order; cfg writes
// the quantum and is always ready.
// An add transaction is resolved in the cycle it is accepted and its result
// is visible on the next cycle. A dispatch reads the head entry from the job
// store, whose read data is registered, and its result is loaded from that
// read data in S_DISPATCH. Adds are accepted at one per cycle while the
// receiver takes each result; no item is accepted during S_DISPATCH.
// Only one item is in flight; the single output register lets a new item be
// accepted in the same cycle that the waiting result is taken.
// If the receiver stalls, the result is held and item.ready stays low until
// the result is taken.
// Reset empties the queue and sets the quantum to 10; the store contents are
// left as they are, since only written entries are ever read.
// ============================================================================
module round_robin_quantum_scheduler (
    input  logic clk,
    input  logic rst_n,
    rrqs_item_if.sink     item,
    rrqs_result_if.source result,
    rrqs_cfg_if.sink      cfg
);
    import rrqs_pkg::*;

    localparam logic S_IDLE     = 1'b0;
    localparam logic S_DISPATCH = 1'b1;

    logic      state_reg, state_next;
    ptr_t      head_reg, head_next;
    ptr_t      tail_reg, tail_next;
    cnt_t      count_reg, count_next;
    job_time_t quantum_reg;

    logic      out_valid_reg, out_valid_next;
    status_t   status_reg, status_next;
    job_id_t   ran_id_reg, ran_id_next;
    job_time_t slice_reg, slice_next;
    job_time_t rem_reg, rem_next;
    logic      out_load;

    store_wr_t wr;
    store_rd_t rd;
    entry_t    rd_data;
    logic      accept;

    rrqs_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        out_load    = 1'b0;
        status_next = status_reg;
        ran_id_next = ran_id_reg;
        slice_next  = slice_reg;
        rem_next    = rem_reg;
        wr          = '0;
        rd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ran_id_next = '0;
                    slice_next  = '0;
                    rem_next    = '0;
                    if (item.op == OP_ADD)
                    begin
                        out_load = 1'b1;
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr.en             = 1'b1;
                            wr.addr           = tail_reg;
                            wr.data.id        = item.job_id;
                            wr.data.remaining = item.duration;
                            tail_next         = next_slot(tail_reg);
                            count_next        = count_reg + cnt_t'(1);
                            status_next       = ST_ADDED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_load    = 1'b1;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd.en      = 1'b1;
                        rd.addr    = head_reg;
                        state_next = S_DISPATCH;
                    end
                end
            end
            S_DISPATCH:
            begin
                out_load    = 1'b1;
                ran_id_next = rd_data.id;
                head_next   = next_slot(head_reg);
                state_next  = S_IDLE;
                if (rd_data.remaining <= quantum_reg)
                begin
                    status_next = ST_COMPLETED;
                    slice_next  = rd_data.remaining;
                    rem_next    = '0;
                    count_next  = count_reg - cnt_t'(1);
                end
                else
                begin
                    // The job goes back to the tail; the queue length is unchanged.
                    status_next       = ST_REQUEUED;
                    slice_next        = quantum_reg;
                    rem_next          = rd_data.remaining - quantum_reg;
                    wr.en             = 1'b1;
                    wr.addr           = tail_reg;
                    wr.data.id        = rd_data.id;
                    wr.data.remaining = rd_data.remaining - quantum_reg;
                    tail_next         = next_slot(tail_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            quantum_reg   <= QUANTUM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                quantum_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_next;
            ran_id_reg <= ran_id_next;
            slice_reg  <= slice_next;
            rem_reg    <= rem_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.status    = status_reg;
    assign result.ran_id    = ran_id_reg;
    assign result.slice_len = slice_reg;
    assign result.remaining = rem_reg;

endmodule
